/* rtl/core/esd_pkg.sv */
// Shared types and character constants for the escape sequence decoder.
`timescale 1ns / 1ps
`default_nettype none

package esd_pkg;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_7      = 8'h37;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [1:0] cnt;
		item_t      r0;
		item_t      r1;
	} res_t;

endpackage

`default_nettype wire

/* rtl/core/esd_decode.sv */
// Escape decode logic and decoder state for one registered character.
`timescale 1ns / 1ps
`default_nettype none

module esd_decode import esd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire item_t      in_s1,
	output res_t            res
);

	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_ESCAPE = 2'd1;
	localparam logic [1:0] MODE_OCTAL  = 2'd2;

	logic [1:0] mode_q, mode_d;
	logic [7:0] oct_q, oct_d;
	logic [7:0] oct_sum;
	logic       is_oct;
	logic       plain_emit;
	logic       plain_esc;
	logic       known;
	logic [7:0] mapped;
	logic [7:0] c;
	logic       lst;

	assign c       = in_s1.ch;
	assign lst     = in_s1.last;
	assign oct_sum = {oct_q[4:0], 3'b000} + {5'b00000, c[2:0]};
	assign is_oct  = c inside {[CH_0:CH_7]};

	always_comb begin
		plain_esc  = (c == CH_BSLASH) && !lst;
		plain_emit = !plain_esc;
		known      = 1'b1;
		case (c)
			CH_BSLASH: mapped = CH_BSLASH;
			CH_QMARK:  mapped = CH_QMARK;
			CH_PCT:    mapped = CH_PCT;
			CH_DQUOTE: mapped = CH_DQUOTE;
			CH_N:      mapped = CH_LF;
			CH_R:      mapped = CH_CR;
			CH_T:      mapped = CH_TAB;
			default: begin
				mapped = 8'h00;
				known  = 1'b0;
			end
		endcase
	end

	always_comb begin
		res    = '0;
		mode_d = mode_q;
		oct_d  = oct_q;
		case (mode_q)
			MODE_ESCAPE: begin
				mode_d = MODE_NORMAL;
				if (known) begin
					res.cnt = 2'd1;
					res.r0  = '{ch: mapped, last: lst};
				end else if (c == CH_0) begin
					oct_d = 8'h00;
					if (lst) begin
						res.cnt = 2'd1;
						res.r0  = '{ch: 8'h00, last: 1'b1};
					end else begin
						mode_d = MODE_OCTAL;
					end
				end else begin
					res.cnt = 2'd2;
					res.r0  = '{ch: CH_BSLASH, last: 1'b0};
					res.r1  = '{ch: c, last: lst};
				end
			end
			MODE_OCTAL: begin
				if (is_oct) begin
					oct_d = oct_sum;
					if (lst) begin
						res.cnt = 2'd1;
						res.r0  = '{ch: oct_sum, last: 1'b1};
					end
				end else begin
					res.r0 = '{ch: oct_q, last: 1'b0};
					mode_d = plain_esc ? MODE_ESCAPE : MODE_NORMAL;
					if (plain_emit) begin
						res.cnt = 2'd2;
						res.r1  = '{ch: c, last: lst};
					end else begin
						res.cnt = 2'd1;
					end
				end
			end
			default: begin
				mode_d = plain_esc ? MODE_ESCAPE : MODE_NORMAL;
				if (plain_emit) begin
					res.cnt = 2'd1;
					res.r0  = '{ch: c, last: lst};
				end
			end
		endcase
		if (lst) begin
			mode_d = MODE_NORMAL;
			oct_d  = 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			oct_q  <= 8'h00;
		end else if (fire) begin
			mode_q <= mode_d;
			oct_q  <= oct_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/esd_fifo.sv */
// Result queue with up to two decoded characters in per cycle, one out if ready.
`timescale 1ns / 1ps
`default_nettype none

module esd_fifo import esd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire res_t       res,
	output logic            room,
	output logic            out_valid,
	output item_t           out_item,
	input  wire logic       out_ready
);

	item_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [CNT_W-1:0]  count_q;
	logic [1:0]        push_cnt;
	logic              pop;
	logic [PTR_W-1:0]  wr_next;

	assign push_cnt  = push ? res.cnt : 2'd0;
	assign out_valid = (count_q != '0);
	assign out_item  = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign room      = (count_q <= CNT_W'(FIFO_DEPTH - 2));
	assign wr_next   = wr_q + PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_q] <= res.r0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_next] <= res.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_W'(push_cnt);
			rd_q    <= rd_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(push_cnt) - CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

/* rtl/core/escape_sequence_decoder.sv */
// Top level of the escape sequence decoder.
// Decodes C style string escapes from a byte stream. One character transfer is
// taken every cycle; a character passes through the input register and the
// result queue before it reaches the output. The output port moves one character
// per cycle while the sink is ready; an unknown escape or an octal run closed by
// a non-backslash character yields two, which a four entry result queue absorbs;
// input transfers pause only while the queue holds three or more characters.
`timescale 1ns / 1ps
`default_nettype none

module escape_sequence_decoder import esd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // [7:0] in_char
	input  wire logic       s_axis_tlast,
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,  // [7:0] out_char
	output logic            m_axis_tlast
);

	logic  valid_s1;
	item_t in_s1;
	logic  fire;
	logic  room;
	res_t  res;
	item_t out_item;

	assign fire          = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			in_s1 <= '{ch: s_axis_tdata, last: s_axis_tlast};
		end
	end

	esd_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.in_s1  (in_s1),
		.res    (res)
	);

	esd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.res       (res),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_item  (out_item),
		.out_ready (m_axis_tready)
	);

	assign m_axis_tdata = out_item.ch;
	assign m_axis_tlast = out_item.last;

endmodule

`default_nettype wire

/* rtl/core/esd_checker.sv */
// Port level checks for the escape sequence decoder and their bind.
`timescale 1ns / 1ps
`default_nettype none

module esd_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	input  wire logic       s_axis_tready,
	input  wire logic       m_axis_tvalid,
	input  wire logic       m_axis_tready,
	input  wire logic [7:0] m_axis_tdata,
	input  wire logic       m_axis_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output valid dropped before transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output payload changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no pending output");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid && !$past(s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
		else $error("output appeared with nothing in flight");

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
